// ===== hdl/avg_pool3d_window_defines.svh =====
// assertion macros used by the checker file
`ifndef AVG_POOL3D_WINDOW_DEFINES_SVH
`define AVG_POOL3D_WINDOW_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define APW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define APW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/apw_pkg.sv =====
// shared types, register codes and defaults for the 3-d average pooling block
package apw_pkg;

  // default sizes of the sample store and the window
  localparam int MAX_DEPTH_DEF  = 16;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_KERNEL_DEF = 8;

  // signed window position: start (7 bits) plus kernel offset, compared to
  // bounds of up to 64 at the default sizes
  localparam int POS_W = 12;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_DEPTH  = 3'd0,
    CFG_KERNEL_HEIGHT = 3'd1,
    CFG_KERNEL_WIDTH  = 3'd2,
    CFG_VOLUME_DEPTH  = 3'd3,
    CFG_VOLUME_HEIGHT = 3'd4,
    CFG_VOLUME_WIDTH  = 3'd5,
    CFG_INV_VOLUME    = 3'd6
  } cfg_index_t;

  // register reset values
  localparam logic [3:0]  KERNEL_DEPTH_RST  = 4'd2;
  localparam logic [3:0]  KERNEL_HEIGHT_RST = 4'd2;
  localparam logic [3:0]  KERNEL_WIDTH_RST  = 4'd2;
  localparam logic [4:0]  VOLUME_DEPTH_RST  = 5'd16;
  localparam logic [6:0]  VOLUME_HEIGHT_RST = 7'd64;
  localparam logic [6:0]  VOLUME_WIDTH_RST  = 7'd64;
  localparam logic [16:0] INV_VOLUME_RST    = 17'd8192;

  typedef struct packed {
    logic [3:0]  kernel_depth;
    logic [3:0]  kernel_height;
    logic [3:0]  kernel_width;
    logic [4:0]  volume_depth;
    logic [6:0]  volume_height;
    logic [6:0]  volume_width;
    logic [16:0] inv_volume;
  } cfg_t;

  // kind of a queued beat
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_POOL = 1'b1
  } op_t;

  // one queued beat between front and back
  typedef struct packed {
    op_t                op;
    logic [3:0]         d;
    logic [5:0]         h;
    logic [5:0]         w;
    logic signed [15:0] value;
    logic signed [4:0]  sd;
    logic signed [6:0]  sh;
    logic signed [6:0]  sw;
  } entry_t;

endpackage

// ===== hdl/apw_ram.sv =====
// generic single-port ram with registered read
module apw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read before write, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/apw_front.sv =====
// front end: accepts beats, drops out-of-range loads, two-entry queue
module apw_front #(
  parameter int MAX_DEPTH  = apw_pkg::MAX_DEPTH_DEF,
  parameter int MAX_HEIGHT = apw_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = apw_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                action,
  input  logic [3:0]          sample_d,
  input  logic [5:0]          sample_h,
  input  logic [5:0]          sample_w,
  input  logic signed [15:0]  sample_value,
  input  logic signed [4:0]   start_d,
  input  logic signed [6:0]   start_h,
  input  logic signed [6:0]   start_w,
  output logic                q_valid,
  output apw_pkg::entry_t     q_entry,
  input  logic                q_pop
);

  apw_pkg::entry_t slots [2];
  apw_pkg::entry_t in_entry;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            accept;
  logic            load_in_range;
  logic            push;

  // classify the incoming beat
  assign load_in_range = (32'(sample_d) < 32'(MAX_DEPTH)) &&
                         (32'(sample_h) < 32'(MAX_HEIGHT)) &&
                         (32'(sample_w) < 32'(MAX_WIDTH));
  assign accept = start && !busy;
  assign push   = accept && (action || load_in_range);

  always_comb begin
    in_entry.op    = action ? apw_pkg::OP_POOL : apw_pkg::OP_LOAD;
    in_entry.d     = sample_d;
    in_entry.h     = sample_h;
    in_entry.w     = sample_w;
    in_entry.value = sample_value;
    in_entry.sd    = start_d;
    in_entry.sh    = start_h;
    in_entry.sw    = start_w;
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_entry;
    end
  end

  assign busy    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_entry = slots[rd_ptr];

endmodule

// ===== hdl/apw_back.sv =====
// back end: writes loads to the sample store, scans pool windows, scales result
module apw_back #(
  parameter int MAX_DEPTH  = apw_pkg::MAX_DEPTH_DEF,
  parameter int MAX_HEIGHT = apw_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = apw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = apw_pkg::MAX_KERNEL_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  apw_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  apw_pkg::entry_t    q_entry,
  output logic               q_pop,
  output logic               done,
  output logic signed [15:0] average
);

  localparam int STORE_DEPTH = MAX_DEPTH * MAX_HEIGHT * MAX_WIDTH;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PLANE       = MAX_HEIGHT * MAX_WIDTH;
  localparam int KC_W        = $clog2(MAX_KERNEL + 1);
  localparam int KLOG        = $clog2(MAX_KERNEL);
  localparam int SUM_W       = 17 + 3 * KLOG;
  localparam int PROD_W      = SUM_W + 18;
  localparam int POS_W       = apw_pkg::POS_W;
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-32768);
  localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(32768);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_MUL,
    S_ROUND
  } state_t;

  state_t                    state;
  logic [KC_W-1:0]           kd_q, kh_q, kw_q;
  logic [KC_W-1:0]           ci, cj, ck;
  logic [KC_W-1:0]           kd_clamp, kh_clamp, kw_clamp;
  logic signed [POS_W-1:0]   sd_q, sh_q, sw_q;
  logic signed [POS_W-1:0]   bd_q, bh_q, bw_q;
  logic signed [POS_W-1:0]   bd_clamp, bh_clamp, bw_clamp;
  logic signed [POS_W-1:0]   pos_d, pos_h, pos_w;
  logic                      in_bounds;
  logic                      rd_pending;
  logic signed [SUM_W-1:0]   sum;
  logic signed [PROD_W-1:0]  product;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [PROD_W-1:0]  shifted;
  logic signed [15:0]        sat_value;
  logic [31:0]               load_lin;
  logic [31:0]               scan_lin;
  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [15:0]               ram_rdata;

  // effective kernel and volume sizes
  assign kd_clamp = (32'(cfg.kernel_depth) > 32'(MAX_KERNEL)) ? KC_W'(MAX_KERNEL)
                                                               : KC_W'(cfg.kernel_depth);
  assign kh_clamp = (32'(cfg.kernel_height) > 32'(MAX_KERNEL)) ? KC_W'(MAX_KERNEL)
                                                                : KC_W'(cfg.kernel_height);
  assign kw_clamp = (32'(cfg.kernel_width) > 32'(MAX_KERNEL)) ? KC_W'(MAX_KERNEL)
                                                               : KC_W'(cfg.kernel_width);
  assign bd_clamp = (32'(cfg.volume_depth) > 32'(MAX_DEPTH)) ? POS_W'(MAX_DEPTH)
                                                              : POS_W'(cfg.volume_depth);
  assign bh_clamp = (32'(cfg.volume_height) > 32'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT)
                                                                : POS_W'(cfg.volume_height);
  assign bw_clamp = (32'(cfg.volume_width) > 32'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH)
                                                              : POS_W'(cfg.volume_width);

  // current window position and bounds check
  assign pos_d = sd_q + $signed(POS_W'(ci));
  assign pos_h = sh_q + $signed(POS_W'(cj));
  assign pos_w = sw_q + $signed(POS_W'(ck));
  assign in_bounds = (pos_d >= 0) && (pos_d < bd_q) &&
                     (pos_h >= 0) && (pos_h < bh_q) &&
                     (pos_w >= 0) && (pos_w < bw_q);

  // store addresses
  assign load_lin = 32'(q_entry.d) * 32'(PLANE) + 32'(q_entry.h) * 32'(MAX_WIDTH) +
                    32'(q_entry.w);
  assign scan_lin = 32'(unsigned'(pos_d)) * 32'(PLANE) +
                    32'(unsigned'(pos_h)) * 32'(MAX_WIDTH) + 32'(unsigned'(pos_w));

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign ram_we   = q_pop && (q_entry.op == apw_pkg::OP_LOAD);
  assign ram_addr = (state == S_IDLE) ? load_lin[AW-1:0] : scan_lin[AW-1:0];

  apw_ram #(
    .WIDTH (16),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (q_entry.value),
    .rdata (ram_rdata)
  );

  // round half up and saturate
  assign rounded = product + HALF;
  assign shifted = rounded >>> 16;
  always_comb begin
    if (shifted > SAT_HI) begin
      sat_value = 16'sh7fff;
    end else if (shifted < SAT_LO) begin
      sat_value = 16'sh8000;
    end else begin
      sat_value = shifted[15:0];
    end
  end

  // sequencer, accumulator and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      done       <= (state == S_ROUND);
      rd_pending <= (state == S_SCAN) && in_bounds;
      if (rd_pending) begin
        sum <= sum + SUM_W'($signed(ram_rdata));
      end
      case (state)
        S_IDLE: begin
          if (q_valid && (q_entry.op == apw_pkg::OP_POOL)) begin
            sd_q <= POS_W'(q_entry.sd);
            sh_q <= POS_W'(q_entry.sh);
            sw_q <= POS_W'(q_entry.sw);
            kd_q <= kd_clamp;
            kh_q <= kh_clamp;
            kw_q <= kw_clamp;
            bd_q <= bd_clamp;
            bh_q <= bh_clamp;
            bw_q <= bw_clamp;
            ci   <= '0;
            cj   <= '0;
            ck   <= '0;
            sum  <= '0;
            if ((kd_clamp == '0) || (kh_clamp == '0) || (kw_clamp == '0)) begin
              state <= S_MUL;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (ck == kw_q - KC_W'(1)) begin
            ck <= '0;
            if (cj == kh_q - KC_W'(1)) begin
              cj <= '0;
              if (ci == kd_q - KC_W'(1)) begin
                state <= S_DRAIN;
              end else begin
                ci <= ci + KC_W'(1);
              end
            end else begin
              cj <= cj + KC_W'(1);
            end
          end else begin
            ck <= ck + KC_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_MUL;
        end
        S_MUL: begin
          product <= PROD_W'(sum) * $signed(PROD_W'(cfg.inv_volume));
          state   <= S_ROUND;
        end
        S_ROUND: begin
          average <= sat_value;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/avg_pool3d_window.sv =====
// top level of the 3-d average pooling block over one stored volume
//
// Usage:
//   input beat: taken at a clock edge with start high and busy low. action low
//   loads sample_value at (sample_d, sample_h, sample_w); action high asks for
//   the average of the window starting at (start_d, start_h, start_w).
//   result beat: done is high for exactly one cycle with average valid; one per
//   pool request, none per load. The receiver cannot stall it.
//   configuration: cfg_we writes cfg_data to register cfg_index at the edge.
// Timing:
//   a front queue of two entries takes beats while the back end works; busy is
//   high only when that queue is full.
//   a load is written to the sample store when the back end pops it; a pool request
//   scans kd*kh*kw window positions (kd, kh, kw the clamped kernel sizes; no scan
//   if any is zero), reading one window sample a cycle through the single store port,
//   then drains, multiplies and rounds; done is registered from the round state.
// Reset:
//   rst clears the queue, the sequencer and the registers to their defaults;
//   the sample store is not cleared, and a scan reads in-bound positions whether loaded or not.
module avg_pool3d_window #(
  parameter int MAX_DEPTH  = apw_pkg::MAX_DEPTH_DEF,
  parameter int MAX_HEIGHT = apw_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = apw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = apw_pkg::MAX_KERNEL_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action,
  input  logic [3:0]                      sample_d,
  input  logic [5:0]                      sample_h,
  input  logic [5:0]                      sample_w,
  input  logic signed [15:0]              sample_value,
  input  logic signed [4:0]               start_d,
  input  logic signed [6:0]               start_h,
  input  logic signed [6:0]               start_w,
  output logic                            done,
  output logic signed [15:0]              average,
  input  logic                            cfg_we,
  input  logic [apw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [apw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  apw_pkg::cfg_t   cfg;
  logic            q_valid;
  logic            q_pop;
  apw_pkg::entry_t q_entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_depth  <= apw_pkg::KERNEL_DEPTH_RST;
      cfg.kernel_height <= apw_pkg::KERNEL_HEIGHT_RST;
      cfg.kernel_width  <= apw_pkg::KERNEL_WIDTH_RST;
      cfg.volume_depth  <= apw_pkg::VOLUME_DEPTH_RST;
      cfg.volume_height <= apw_pkg::VOLUME_HEIGHT_RST;
      cfg.volume_width  <= apw_pkg::VOLUME_WIDTH_RST;
      cfg.inv_volume    <= apw_pkg::INV_VOLUME_RST;
    end else if (cfg_we) begin
      case (apw_pkg::cfg_index_t'(cfg_index))
        apw_pkg::CFG_KERNEL_DEPTH:  cfg.kernel_depth  <= cfg_data[3:0];
        apw_pkg::CFG_KERNEL_HEIGHT: cfg.kernel_height <= cfg_data[3:0];
        apw_pkg::CFG_KERNEL_WIDTH:  cfg.kernel_width  <= cfg_data[3:0];
        apw_pkg::CFG_VOLUME_DEPTH:  cfg.volume_depth  <= cfg_data[4:0];
        apw_pkg::CFG_VOLUME_HEIGHT: cfg.volume_height <= cfg_data[6:0];
        apw_pkg::CFG_VOLUME_WIDTH:  cfg.volume_width  <= cfg_data[6:0];
        apw_pkg::CFG_INV_VOLUME:    cfg.inv_volume    <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  // accept and queue
  apw_front #(
    .MAX_DEPTH  (MAX_DEPTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .sample_d     (sample_d),
    .sample_h     (sample_h),
    .sample_w     (sample_w),
    .sample_value (sample_value),
    .start_d      (start_d),
    .start_h      (start_h),
    .start_w      (start_w),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop)
  );

  // store, window scan and scaling
  apw_back #(
    .MAX_DEPTH  (MAX_DEPTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .done    (done),
    .average (average)
  );

endmodule

// ===== hdl/apw_checker.sv =====
// port-level checks for the pooling block, bound to the top level
`include "avg_pool3d_window_defines.svh"

module apw_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] average
);

  // a pool result passes the idle, multiply and round states, so result beats never touch
  `APW_ASSERT_NEXT(a_done_gap, done, !done, "two result beats in adjacent cycles")

  // the queue fills only through an accepted beat
  `APW_ASSERT_NOW(a_busy_cause, $rose(busy), $past(start && !busy), "busy rose without a beat")

  // the queue is empty right after reset
  `APW_ASSERT_NOW(a_reset_idle, $past(rst), !busy && !done, "busy or done just after reset")

  // a result beat always carries a known average
  `APW_ASSERT_NOW(a_average_known, done, !$isunknown(average), "unknown average on a result beat")

endmodule

bind avg_pool3d_window apw_checker u_apw_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .average (average)
);
